@@ design/mbf_pkg.sv @@
package mbf_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // divider geometry
  localparam int unsigned NUM_W = 32;
  localparam int unsigned DEN_W = 33;

  // field sum saturates here, one above the largest reported level
  localparam logic [16:0] SUM_SAT = 17'h10000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         ball_index;
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic [5:0]         ball_radius;
    logic [15:0]        step_time;
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
  } item_t;

  typedef struct packed {
    logic        inside_res;
    logic [15:0] field_level;
  } result_t;

  typedef struct packed {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic [5:0]         r;
  } ball_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_SQ,
    ST_PIX_D2,
    ST_PIX_DIV,
    ST_PIX_ACC,
    ST_TK_MUL,
    ST_TK_ADD,
    ST_TK_DIV,
    ST_TK_FIX,
    ST_TK_WB
  } state_e;

endpackage

@@ design/mbf_cell.sv @@
module mbf_cell #(
  parameter int IDX = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic [2:0]     load_idx_i,
  input  mbf_pkg::ball_t load_ball_i,
  input  logic           shift_i,
  input  mbf_pkg::ball_t next_i,
  output mbf_pkg::ball_t ball_o
);

  mbf_pkg::ball_t ball_q, ball_d;

  // load of this entry, or hand-over from the neighbor
  always_comb begin
    ball_d = ball_q;
    if (load_i && (32'(load_idx_i) == IDX)) begin
      ball_d = load_ball_i;
    end else if (shift_i) begin
      ball_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_q <= '0;
    end else begin
      ball_q <= ball_d;
    end
  end

  assign ball_o = ball_q;

endmodule

@@ design/mbf_div.sv @@
module mbf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mbf_pkg::NUM_W-1:0]   num_i,
  input  logic [mbf_pkg::DEN_W-1:0]   den_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [mbf_pkg::NUM_W-1:0]   quo_o
);

  localparam logic [5:0] STEPS = 6'(mbf_pkg::NUM_W);

  logic [mbf_pkg::NUM_W-1:0] num_q;
  logic [mbf_pkg::DEN_W-1:0] rem_q, den_q;
  logic [5:0]                cnt_q;
  logic                      done_q;
  logic [mbf_pkg::DEN_W:0]   trial, diff;
  logic                      ge;

  // one restoring step: shift in the next numerator bit, try a subtract
  always_comb begin
    trial = {rem_q, num_q[mbf_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 6'd1);
      if (start_i) begin
        cnt_q <= STEPS;
      end else if (cnt_q != 6'd0) begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  // quotient bits collect in the numerator register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != 6'd0) begin
      rem_q <= ge ? diff[mbf_pkg::DEN_W-1:0] : trial[mbf_pkg::DEN_W-1:0];
      num_q <= {num_q[mbf_pkg::NUM_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != 6'd0);
  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

@@ design/metaball_field_threshold_core.sv @@
// Metaball field and threshold unit.
// A command word is taken on a rising edge with start_i high and busy_o low.
// Words: load one ball into the table, sample one pixel, or advance time.
// Load and unused commands return nothing; the unit stays idle.
// A pixel word returns one result word on res_o, marked by res_valid_o for
// exactly one cycle; the receiver cannot stall, so it must take it then.
// The balls sit in a ring of cells that rotates one place per ball; the head
// cell feeds a shared 32-step restoring divider. Per ball a pixel walks a
// squaring stage, the divider and an accumulate.
// A tick walks per ball and per axis one multiply, one add, one reciprocal
// multiply that divides the position by the screen edge and one fix-up that
// folds it against the edge, then one write-back per ball.
// busy_o stays high for the whole walk; the next word is taken after it.
// Reset clears every ball to zero at once and leaves the unit idle.
module metaball_field_threshold_core #(
  parameter int BALL_COUNT    = 5,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mbf_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output mbf_pkg::result_t res_o
);

  localparam int CNT_W = (BALL_COUNT > 1) ? $clog2(BALL_COUNT) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(BALL_COUNT - 1);
  localparam logic [15:0] MX = 16'((SCREEN_WIDTH - 1) * 64);
  localparam logic [15:0] MY = 16'((SCREEN_HEIGHT - 1) * 64);
  // ceil(2^33 / m): exact quotient for any 17-bit numerator
  localparam logic [27:0] RCP_X = 28'(((64'd1 << 33) + 64'(MX) - 64'd1) / 64'(MX));
  localparam logic [27:0] RCP_Y = 28'(((64'd1 << 33) + 64'(MY) - 64'd1) / 64'(MY));

  mbf_pkg::state_e st_q, st_d;
  logic [CNT_W-1:0] cnt_q;
  logic             axis_q;
  logic [16:0]      sum_q;
  logic [31:0]      sqx_q, sqy_q, num_q;
  logic signed [32:0] prod_q;
  logic             neg_q, zero_q;
  logic [16:0]      a_q;
  logic [11:0]      quo_q;
  mbf_pkg::ball_t   wb_q;
  logic [9:0]       pix_x_q, pix_y_q;
  logic [15:0]      dt_q;
  mbf_pkg::result_t res_q;
  logic             res_valid_q;

  logic accept, load_en, shift_en;
  mbf_pkg::ball_t ball [BALL_COUNT];
  mbf_pkg::ball_t head, feed, load_ball;

  // ring of ball cells, head at index zero
  assign load_ball = '{cx: item_i.center_x, cy: item_i.center_y, sx: item_i.speed_x,
                       sy: item_i.speed_y, r: item_i.ball_radius};
  assign head = ball[0];

  for (genvar i = 0; i < BALL_COUNT; i++) begin : g_cell
    mbf_pkg::ball_t nxt;
    if (i == BALL_COUNT - 1) begin : g_tail
      assign nxt = feed;
    end else begin : g_mid
      assign nxt = ball[i+1];
    end
    mbf_cell #(.IDX(i)) u_cell (
      .clk_i, .rst_ni,
      .load_i(load_en), .load_idx_i(item_i.ball_index), .load_ball_i(load_ball),
      .shift_i(shift_en), .next_i(nxt), .ball_o(ball[i])
    );
  end

  // pixel datapath
  logic signed [16:0] dx, dy;
  logic signed [33:0] sqx, sqy;
  logic [11:0]        rr;
  logic [32:0]        d2, d2f;
  logic [32:0]        sum_add;
  logic [16:0]        sum_new;
  always_comb begin
    dx  = $signed({1'b0, pix_x_q, 6'b0}) - $signed({1'b0, head.cx});
    dy  = $signed({1'b0, pix_y_q, 6'b0}) - $signed({1'b0, head.cy});
    sqx = dx * dx;
    sqy = dy * dy;
    rr  = 12'(head.r) * 12'(head.r);
    d2  = {1'b0, sqx_q} + {1'b0, sqy_q};
    d2f = (d2 == 33'd0) ? 33'd1 : d2;
  end

  // tick datapath
  logic [15:0]        pos_sel, m_sel, pos_new;
  logic [27:0]        rcp_sel;
  logic signed [15:0] spd_sel, spd_neg, spd_new;
  logic signed [32:0] prod;
  logic signed [16:0] delta;
  logic signed [17:0] p;
  logic [16:0]        a, am1, qm;
  logic [44:0]        rcp_prod;
  logic               par;
  always_comb begin
    pos_sel  = axis_q ? head.cy : head.cx;
    spd_sel  = axis_q ? head.sy : head.sx;
    m_sel    = axis_q ? MY : MX;
    rcp_sel  = axis_q ? RCP_Y : RCP_X;
    prod     = $signed({{17{spd_sel[15]}}, spd_sel}) * $signed({17'b0, dt_q});
    delta    = prod_q[32:16];
    p        = $signed({2'b0, pos_sel}) + $signed({delta[16], delta});
    a        = p[17] ? 17'(-p) : p[16:0];
    am1      = a_q - 17'd1;
    rcp_prod = 45'(am1) * 45'(rcp_sel);
    spd_neg  = (spd_sel == 16'sh8000) ? 16'sh7fff : -spd_sel;
  end

  // shared divider for the field terms
  logic        div_start, div_busy, div_done;
  logic [31:0] div_num, div_quo;
  logic [32:0] div_den;
  assign div_start = (st_q == mbf_pkg::ST_PIX_D2);
  assign div_num   = num_q;
  assign div_den   = d2f;

  mbf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  // fold against the edge: quotient parity picks the mirror side
  always_comb begin
    qm      = 17'(quo_q) * 17'(m_sel);
    pos_new = zero_q ? 16'd0 :
              (quo_q[0] ? 16'(qm + 17'(m_sel) - a_q) : 16'(a_q - qm));
    par     = !zero_q && (quo_q[0] ^ neg_q);
    spd_new = par ? spd_neg : spd_sel;
    sum_add = {16'b0, sum_q} + {1'b0, div_quo};
    sum_new = (sum_add > 33'(mbf_pkg::SUM_SAT)) ? mbf_pkg::SUM_SAT : sum_add[16:0];
  end

  assign feed   = (st_q == mbf_pkg::ST_TK_WB) ? wb_q : head;
  assign accept = start_i && (st_q == mbf_pkg::ST_IDLE);

  // sequencer
  always_comb begin
    st_d     = st_q;
    load_en  = 1'b0;
    shift_en = 1'b0;
    case (st_q)
      mbf_pkg::ST_IDLE: begin
        if (accept) begin
          case (item_i.cmd)
            mbf_pkg::CMD_LOAD:  load_en = 1'b1;
            mbf_pkg::CMD_PIXEL: st_d = mbf_pkg::ST_PIX_SQ;
            mbf_pkg::CMD_TICK:  st_d = mbf_pkg::ST_TK_MUL;
            default:            st_d = mbf_pkg::ST_IDLE;
          endcase
        end
      end
      mbf_pkg::ST_PIX_SQ:  st_d = mbf_pkg::ST_PIX_D2;
      mbf_pkg::ST_PIX_D2:  st_d = mbf_pkg::ST_PIX_DIV;
      mbf_pkg::ST_PIX_DIV: if (div_done) st_d = mbf_pkg::ST_PIX_ACC;
      mbf_pkg::ST_PIX_ACC: begin
        shift_en = 1'b1;
        st_d = (cnt_q == LAST) ? mbf_pkg::ST_IDLE : mbf_pkg::ST_PIX_SQ;
      end
      mbf_pkg::ST_TK_MUL:  st_d = mbf_pkg::ST_TK_ADD;
      mbf_pkg::ST_TK_ADD:  st_d = mbf_pkg::ST_TK_DIV;
      mbf_pkg::ST_TK_DIV:  st_d = mbf_pkg::ST_TK_FIX;
      mbf_pkg::ST_TK_FIX:  st_d = axis_q ? mbf_pkg::ST_TK_WB : mbf_pkg::ST_TK_MUL;
      mbf_pkg::ST_TK_WB: begin
        shift_en = 1'b1;
        st_d = (cnt_q == LAST) ? mbf_pkg::ST_IDLE : mbf_pkg::ST_TK_MUL;
      end
      default: st_d = mbf_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= mbf_pkg::ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= (st_q == mbf_pkg::ST_PIX_ACC) && (cnt_q == LAST);
      if (accept) begin
        cnt_q  <= '0;
        axis_q <= 1'b0;
      end else begin
        if (shift_en) cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + CNT_W'(1);
        if (st_q == mbf_pkg::ST_TK_FIX) axis_q <= !axis_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_x_q <= item_i.pixel_x;
      pix_y_q <= item_i.pixel_y;
      dt_q    <= item_i.step_time;
      sum_q   <= '0;
    end
    if (st_q == mbf_pkg::ST_PIX_SQ) begin
      sqx_q <= sqx[31:0];
      sqy_q <= sqy[31:0];
      num_q <= {rr, 20'b0};
    end
    if (st_q == mbf_pkg::ST_PIX_ACC) begin
      sum_q <= sum_new;
      res_q.inside_res  <= (sum_new >= 17'd256);
      res_q.field_level <= sum_new[16] ? 16'hffff : sum_new[15:0];
    end
    if (st_q == mbf_pkg::ST_TK_MUL) prod_q <= prod;
    if (st_q == mbf_pkg::ST_TK_ADD) begin
      neg_q  <= p[17];
      zero_q <= (a == 17'd0);
      a_q    <= a;
    end
    // quotient of (a - 1) by the edge, top bits of the reciprocal product
    if (st_q == mbf_pkg::ST_TK_DIV) quo_q <= rcp_prod[44:33];
    if (st_q == mbf_pkg::ST_TK_FIX) begin
      if (!axis_q) begin
        wb_q <= '{cx: pos_new, cy: head.cy, sx: spd_new, sy: head.sy, r: head.r};
      end else begin
        wb_q <= '{cx: wb_q.cx, cy: pos_new, sx: wb_q.sx, sy: spd_new, r: wb_q.r};
      end
    end
  end

  assign busy_o      = (st_q != mbf_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // result only follows an accumulate of a pixel walk
  a_res_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(st_q == mbf_pkg::ST_PIX_ACC))
    else $error("result without pixel walk");

  // lit flag agrees with the level
  a_res_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.inside_res == (res_o.field_level >= 16'd256)))
    else $error("inside flag disagrees with level");

  // divider is never restarted while running
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

@@ bench/tb_checker.sv @@
`timescale 1ns / 1ps

module tb_checker #(
  parameter int BALL_COUNT    = 5,
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 200
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mbf_pkg::item_t   item_i,
  input  logic             busy_i,
  input  logic             res_valid_i,
  input  mbf_pkg::result_t res_i,
  output int               fail_count_o,
  output int               pending_o
);

  // shadow ball table
  logic [15:0] ball_cx [BALL_COUNT];
  logic [15:0] ball_cy [BALL_COUNT];
  logic [15:0] ball_sx [BALL_COUNT];
  logic [15:0] ball_sy [BALL_COUNT];
  logic [5:0]  ball_r  [BALL_COUNT];

  mbf_pkg::result_t field_q[$];

  assign pending_o = field_q.size();

  function automatic logic [15:0] negate_sat(input logic [15:0] v);
    if (v == 16'h8000) return 16'h7fff;
    return -v;
  endfunction

  // one axis of a tick: move, fold into the screen, track reflection parity
  task automatic advance_axis(inout logic [15:0] pos, inout logic [15:0] spd,
                              input logic [15:0] dt, input int size);
    longint prod, delta, lim, p;
    bit flips;
    prod  = longint'($signed(spd)) * longint'(dt);
    delta = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
    lim   = longint'(size - 1) * 64;
    p     = longint'(pos) + delta;
    flips = 0;
    while (p < 0 || p > lim) begin
      if (p < 0) p = -p;
      else p = 2 * lim - p;
      flips = ~flips;
    end
    if (flips) spd = negate_sat(spd);
    pos = p[15:0];
  endtask

  function automatic mbf_pkg::result_t sample_field(input logic [9:0] px,
                                                    input logic [9:0] py);
    longint dx, dy, d2, sum, rr;
    mbf_pkg::result_t res;
    sum = 0;
    for (int i = 0; i < BALL_COUNT; i++) begin
      dx = longint'(px) * 64 - longint'(ball_cx[i]);
      dy = longint'(py) * 64 - longint'(ball_cy[i]);
      d2 = dx * dx + dy * dy;
      if (d2 < 1) d2 = 1;
      rr = longint'(ball_r[i]);
      sum += ((rr * rr) << 20) / d2;
    end
    res.inside_res  = (sum >= 256);
    res.field_level = (sum > 65535) ? 16'hffff : sum[15:0];
    return res;
  endfunction

  // predict on accepted words, compare on strobed results
  always @(posedge clk_i or negedge rst_ni) begin
    mbf_pkg::result_t got, want;
    logic [15:0] tp, ts;
    if (!rst_ni) begin
      for (int i = 0; i < BALL_COUNT; i++) begin
        ball_cx[i] = 0; ball_cy[i] = 0; ball_sx[i] = 0; ball_sy[i] = 0; ball_r[i] = 0;
      end
      field_q.delete();
      fail_count_o = 0;
    end else begin
      if (res_valid_i) begin
        got = res_i;
        if (field_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count_o++;
        end else begin
          want = field_q.pop_front();
          if (got.inside_res !== want.inside_res) begin
            $display("%0t: inside expected %b actual %b", $time, want.inside_res,
                     got.inside_res);
            fail_count_o++;
          end
          if (got.field_level !== want.field_level) begin
            $display("%0t: level expected %h actual %h", $time, want.field_level,
                     got.field_level);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        case (item_i.cmd)
          mbf_pkg::CMD_LOAD: begin
            if (item_i.ball_index < BALL_COUNT) begin
              ball_cx[item_i.ball_index] = item_i.center_x;
              ball_cy[item_i.ball_index] = item_i.center_y;
              ball_sx[item_i.ball_index] = item_i.speed_x;
              ball_sy[item_i.ball_index] = item_i.speed_y;
              ball_r[item_i.ball_index]  = item_i.ball_radius;
            end
          end
          mbf_pkg::CMD_PIXEL: field_q.push_back(sample_field(item_i.pixel_x, item_i.pixel_y));
          mbf_pkg::CMD_TICK: begin
            for (int i = 0; i < BALL_COUNT; i++) begin
              tp = ball_cx[i]; ts = ball_sx[i];
              advance_axis(tp, ts, item_i.step_time, SCREEN_WIDTH);
              ball_cx[i] = tp; ball_sx[i] = ts;
              tp = ball_cy[i]; ts = ball_sy[i];
              advance_axis(tp, ts, item_i.step_time, SCREEN_HEIGHT);
              ball_cy[i] = tp; ball_sy[i] = ts;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_WORDS = 1300;
  localparam int IDLE_LIMIT   = 20000;

  logic             clk_i, rst_ni, start_i, busy_o, res_valid_o;
  mbf_pkg::item_t   item_i;
  mbf_pkg::result_t res_o;
  int               fail_count, pending;
  int               idle_cycles;

  metaball_field_threshold_core dut (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .res_valid_o, .res_o
  );

  tb_checker chk (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_i(busy_o), .res_valid_i(res_valid_o),
    .res_i(res_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog on cycles with no accepted word or result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic mbf_pkg::item_t rand_word();
    logic [127:0] raw;
    mbf_pkg::item_t w;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(mbf_pkg::item_t)-1:0];
    return w;
  endfunction

  function automatic mbf_pkg::item_t load_word(input int idx, input int cx, input int cy,
                                               input int sx, input int sy, input int r);
    mbf_pkg::item_t w;
    w = rand_word();
    w.cmd = mbf_pkg::CMD_LOAD; w.ball_index = 3'(idx);
    w.center_x = 16'(cx); w.center_y = 16'(cy);
    w.speed_x = 16'(sx); w.speed_y = 16'(sy); w.ball_radius = 6'(r);
    return w;
  endfunction

  function automatic mbf_pkg::item_t pixel_word(input int x, input int y);
    mbf_pkg::item_t w;
    w = rand_word();
    w.cmd = mbf_pkg::CMD_PIXEL; w.pixel_x = 10'(x); w.pixel_y = 10'(y);
    return w;
  endfunction

  function automatic mbf_pkg::item_t tick_word(input int dt);
    mbf_pkg::item_t w;
    w = rand_word();
    w.cmd = mbf_pkg::CMD_TICK; w.step_time = 16'(dt);
    return w;
  endfunction

  // send one word, with a random gap before it; start stays up with no gap
  task automatic send_word(input mbf_pkg::item_t w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // stop sending and wait for every expected result
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // a word mostly aimed at the visible screen
  function automatic mbf_pkg::item_t random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 12)
      return load_word($urandom_range(0, 4), $urandom_range(0, 319 * 64),
                       $urandom_range(0, 199 * 64), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), $urandom_range(0, 63));
    if (k < 15) return rand_word();
    if (k < 22) return tick_word($urandom_range(0, 65535));
    if (k < 30) return pixel_word($urandom_range(0, 1023), $urandom_range(0, 1023));
    return pixel_word($urandom_range(0, 319), $urandom_range(0, 199));
  endfunction

  initial begin
    start_i = 0;
    item_i  = '0;
    rst_ni  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, extremes, edge cases
    send_word(pixel_word(0, 0));
    send_word(load_word(0, 0, 0, 16'h8000, 16'h8000, 63));
    send_word(pixel_word(0, 0));
    send_word(pixel_word(1023, 1023));
    send_word(load_word(1, 65535, 65535, 16'h7fff, 16'h7fff, 63));
    send_word(load_word(2, 160 * 64, 100 * 64, 0, 0, 0));
    send_word(load_word(5, 100, 100, 100, 100, 40));
    send_word(load_word(7, 100, 100, 100, 100, 40));
    send_word(load_word(3, 100 * 64, 50 * 64, 16'h0140, 16'hfec0, 20));
    send_word(load_word(4, 200 * 64 + 32, 150 * 64, 16'hffff, 1, 1));
    send_word(pixel_word(100, 50));
    send_word(pixel_word(160, 100));
    send_word(pixel_word(1023, 1023));
    begin
      mbf_pkg::item_t w;
      w = rand_word(); w.cmd = mbf_pkg::CMD_NONE;
      send_word(w);
    end
    send_word(tick_word(65535));
    send_word(tick_word(0));
    send_word(pixel_word(0, 0));
    send_word(tick_word(1));
    send_word(tick_word(32768));
    send_word(pixel_word(319, 199));

    // hold off until the pipeline drains
    drain();
    repeat (5) @(posedge clk_i);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(random_item());
      if (n == RANDOM_WORDS / 2) drain();
    end

    drain();
    repeat (400) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
